/* sv/rgb_hls_colour_converter_macros.svh */
// Assertion macros shared by the colour converter RTL.
`ifndef RGB_HLS_COLOUR_CONVERTER_MACROS_SVH
`define RGB_HLS_COLOUR_CONVERTER_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define RHC_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define RHC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/rhc_pkg.sv */
// Types and constants of the RGB/HLS colour converter.
package rhc_pkg;

   localparam int unsigned ONE_Q16    = 65536;
   localparam int unsigned HALF_Q16   = 32768;
   localparam int unsigned FULL_TURN  = 23040;
   localparam int unsigned THIRD_TURN = 7680;
   localparam int unsigned SIXTH_TURN = 3840;
   localparam int unsigned HUE_MAX    = 23039;

   localparam logic ACT_RGB_TO_HLS = 1'b0;
   localparam logic ACT_HLS_TO_RGB = 1'b1;

   // Divider geometry: two quotient bits per stage.
   localparam int unsigned DIV_DW     = 8;
   localparam int unsigned DIV_QW     = 17;
   localparam int unsigned DIV_STAGES = (DIV_QW + 1) / 2;
   localparam int unsigned SAT_NW     = 24;
   localparam int unsigned HUE_NW     = 20;
   localparam int unsigned REV_STAGES = 3;

   typedef struct packed {
      logic        action;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [14:0] hue;
      logic [16:0] lightness;
      logic [16:0] saturation;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [14:0] out_hue;
      logic [16:0] out_lightness;
      logic [16:0] out_saturation;
   } rsp_type;

   typedef struct packed {
      logic        action;
      logic        achro;
      logic [16:0] lightness;
      logic [14:0] hue_base;
      logic        hue_neg;
      logic [23:0] sat_num;
      logic [7:0]  sat_den;
      logic [19:0] hue_num;
      logic [7:0]  hue_den;
      logic [16:0] lc;
      logic [16:0] sc;
      logic [14:0] hw;
      logic [32:0] p_ls;
   } prep_type;

   typedef struct packed {
      logic        action;
      logic        achro;
      logic [16:0] lightness;
   } fwd_tag_type;

   typedef struct packed {
      logic        hue_neg;
      logic [14:0] hue_base;
   } hue_tag_type;

endpackage

/* sv/rhc_prep.sv */
// Front stage: forward min/max, divider operands, lightness; reverse clamps and l*s.
module rhc_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rhc_pkg::req_type  req,
   output logic              out_valid,
   output rhc_pkg::prep_type prep
);
   import rhc_pkg::*;

   logic [7:0]  mx, mn, span, dd;
   logic [8:0]  total, lfrac;
   logic [15:0] ly;
   prep_type    prep_in, prep_ff;
   logic        valid_ff;

   always_comb begin
      mx = req.red;
      mn = req.red;
      if (req.green > mx) mx = req.green;
      if (req.blue > mx) mx = req.blue;
      if (req.green < mn) mn = req.green;
      if (req.blue < mn) mn = req.blue;
      total = {1'b0, mx} + {1'b0, mn};
      span  = mx - mn;
      prep_in = '0;
      prep_in.action = req.action;
      prep_in.achro  = (mx == mn);

      // total*65536/510 = total*128 + total*128/255
      ly    = {total[8:0], 7'b0};
      lfrac = 9'((17'(ly) + 17'd1 + 17'(ly[15:8])) >> 8);
      prep_in.lightness = 17'(ly) + 17'(lfrac);

      prep_in.sat_num = {span, 16'b0};
      if (mx == mn) begin
         prep_in.sat_den = 8'd1;
      end else if (total < 9'd255) begin
         prep_in.sat_den = total[7:0];
      end else begin
         prep_in.sat_den = 8'(9'd510 - total);
      end

      // sector base and magnitude of the in-sector offset
      if (req.red == mx) begin
         if (req.green >= req.blue) begin
            prep_in.hue_base = 15'd0;
            prep_in.hue_neg  = 1'b0;
            dd = req.green - req.blue;
         end else begin
            prep_in.hue_base = 15'(FULL_TURN);
            prep_in.hue_neg  = 1'b1;
            dd = req.blue - req.green;
         end
      end else if (req.green == mx) begin
         prep_in.hue_base = 15'(2 * SIXTH_TURN);
         prep_in.hue_neg  = (req.blue < req.red);
         dd = (req.blue < req.red) ? req.red - req.blue : req.blue - req.red;
      end else begin
         prep_in.hue_base = 15'(4 * SIXTH_TURN);
         prep_in.hue_neg  = (req.red < req.green);
         dd = (req.red < req.green) ? req.green - req.red : req.red - req.green;
      end
      prep_in.hue_num = 20'(dd) * 20'(SIXTH_TURN);
      prep_in.hue_den = (mx == mn) ? 8'd1 : span;

      prep_in.lc = (req.lightness > 17'(ONE_Q16)) ? 17'(ONE_Q16) : req.lightness;
      prep_in.sc = (req.saturation > 17'(ONE_Q16)) ? 17'(ONE_Q16) : req.saturation;
      prep_in.hw = (req.hue >= 15'(FULL_TURN)) ? req.hue - 15'(FULL_TURN) : req.hue;
      prep_in.p_ls = 33'(prep_in.lc) * 33'(prep_in.sc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
      end
   end

   assign out_valid = valid_ff;
   assign prep      = prep_ff;

endmodule

/* sv/rhc_div.sv */
// Pipelined restoring divider, two quotient bits per stage, with a carried tag.
module rhc_div #(
   parameter int unsigned NW = rhc_pkg::SAT_NW,
   parameter int unsigned DW = rhc_pkg::DIV_DW,
   parameter int unsigned QW = rhc_pkg::DIV_QW,
   parameter int unsigned TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] quot,
   output logic [DW-1:0] rem,
   output logic [TW-1:0] out_tag
);
   localparam int unsigned ST = (QW + 1) / 2;
   localparam int unsigned QP = 2 * ST;

   logic [DW-1:0] rem_ff [ST];
   logic [DW-1:0] rem_in [ST];
   logic [DW-1:0] den_ff [ST];
   logic [DW-1:0] den_in [ST];
   logic [QP-1:0] w_ff   [ST];
   logic [QP-1:0] w_in   [ST];
   logic [TW-1:0] tag_ff [ST];
   logic [TW-1:0] tag_in [ST];
   logic [ST-1:0] valid_ff;
   logic [ST-1:0] valid_in;

   for (genvar s = 0; s < ST; s++) begin : g_stage
      logic [DW-1:0] r_src;
      logic [QP-1:0] w_src;
      logic [DW:0]   t1, t2;
      logic [DW-1:0] r1;
      logic          b1, b2;

      if (s == 0) begin : g_first
         // the bits above the QP shifted ones form the starting remainder
         assign r_src       = DW'(num >> QP);
         assign w_src       = QP'(num);
         assign den_in[s]   = den;
         assign tag_in[s]   = in_tag;
         assign valid_in[s] = in_valid;
      end else begin : g_next
         assign r_src       = rem_ff[s-1];
         assign w_src       = w_ff[s-1];
         assign den_in[s]   = den_ff[s-1];
         assign tag_in[s]   = tag_ff[s-1];
         assign valid_in[s] = valid_ff[s-1];
      end

      // two dependent subtract-and-compare steps
      assign t1 = {r_src, w_src[QP-1]};
      assign b1 = (t1 >= {1'b0, den_in[s]});
      assign r1 = b1 ? DW'(t1 - {1'b0, den_in[s]}) : t1[DW-1:0];
      assign t2 = {r1, w_src[QP-2]};
      assign b2 = (t2 >= {1'b0, den_in[s]});
      assign rem_in[s] = b2 ? DW'(t2 - {1'b0, den_in[s]}) : t2[DW-1:0];
      assign w_in[s]   = {w_src[QP-3:0], b1, b2};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in[s];
            w_ff[s]   <= w_in[s];
            den_ff[s] <= den_in[s];
            tag_ff[s] <= tag_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[ST-1];
   assign quot      = w_ff[ST-1][QW-1:0];
   assign rem       = rem_ff[ST-1];
   assign out_tag   = tag_ff[ST-1];

endmodule

/* sv/rhc_rev.sv */
// Reverse path: HLS levels, hue ramp weights and channel scaling over three stages.
module rhc_rev (
   input  logic              clock,
   input  logic              en,
   input  rhc_pkg::prep_type prep,
   output logic [23:0]       rgb
);
   import rhc_pkg::*;

   function automatic logic [11:0] ramp_weight(input logic [14:0] a);
      logic [11:0] w;
      if (a < 15'(SIXTH_TURN)) begin
         w = a[11:0];
      end else if (a < 15'(3 * SIXTH_TURN)) begin
         w = 12'(SIXTH_TURN);
      end else if (a < 15'(4 * SIXTH_TURN)) begin
         w = 12'(15'(4 * SIXTH_TURN) - a);
      end else begin
         w = 12'd0;
      end
      return w;
   endfunction

   logic [33:0] hi_c;
   logic [32:0] hi, lo_in, lo_ff, diff_in, diff_ff;
   logic [15:0] ang_red;
   logic [14:0] ang [3];
   logic [11:0] w_in [3];
   logic [11:0] w_ff [3];
   logic [44:0] base_in, base_ff;
   logic [44:0] prod_in [3];
   logic [44:0] prod_ff [3];
   logic [44:0] num [3];
   logic [48:0] x [3];
   logic [8:0]  ch9 [3];
   logic [7:0]  ch_in [3];
   logic [7:0]  ch_ff [3];

   // levels hi and lo in Q32
   always_comb begin
      if (prep.lc <= 17'(HALF_Q16)) begin
         hi_c = (34'(prep.lc) << 16) + 34'(prep.p_ls);
      end else begin
         hi_c = ((34'(prep.lc) + 34'(prep.sc)) << 16) - 34'(prep.p_ls);
      end
      hi      = 33'(hi_c);
      lo_in   = 33'((34'(prep.lc) << 17) - hi_c);
      diff_in = hi - lo_in;

      ang_red = 16'(prep.hw) + 16'(THIRD_TURN);
      if (ang_red > 16'(FULL_TURN)) ang_red = ang_red - 16'(FULL_TURN);
      ang[0] = 15'(ang_red);
      ang[1] = prep.hw;
      ang[2] = (prep.hw >= 15'(THIRD_TURN)) ? prep.hw - 15'(THIRD_TURN)
                                            : prep.hw + 15'(FULL_TURN - THIRD_TURN);
      for (int c = 0; c < 3; c++) begin
         w_in[c] = ramp_weight(ang[c]);
      end
   end

   always_comb begin
      base_in = 45'(lo_ff) * 45'(SIXTH_TURN);
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = 45'(diff_ff) * 45'(w_ff[c]);
      end
   end

   // channel = level * 255 / (3840 << 32) = level * 17 >> 40
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num[c]   = base_ff + prod_ff[c];
         x[c]     = (49'(num[c]) << 4) + 49'(num[c]);
         ch9[c]   = 9'(x[c] >> 40);
         ch_in[c] = (ch9[c] > 9'd255) ? 8'd255 : ch9[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         diff_ff <= diff_in;
         base_ff <= base_in;
         for (int c = 0; c < 3; c++) begin
            w_ff[c]    <= w_in[c];
            prod_ff[c] <= prod_in[c];
            ch_ff[c]   <= ch_in[c];
         end
      end
   end

   assign rgb = {ch_ff[0], ch_ff[1], ch_ff[2]};

endmodule

/* sv/rgb_hls_colour_converter.sv */
// Top level of the RGB/HLS colour converter pipeline.
//
// Each transfer on the req_ channel carries one item; action 0 turns the 8-bit
// red/green/blue pixel into hue (1/64 degree), lightness and saturation (Q1.16),
// action 1 turns hue/lightness/saturation into 8-bit red/green/blue. Every item
// produces exactly one transfer on the rsp_ channel, in order; the fields of
// the direction not asked for are zero.
//
// From an accepted req_ transfer to rsp_valid an item passes through one front
// stage, nine stages of the pipelined dividers (two quotient bits each, set by
// the 17-bit saturation quotient) and the output register. The reverse path
// runs three stages beside the dividers and is delayed to line up.
// Throughput is one item per clock while rsp_stall does not hold the pipeline.
//
// Reset clears every valid bit; payload registers are left as they are.
// While rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised; nothing is dropped or repeated.
`include "rgb_hls_colour_converter_macros.svh"

module rgb_hls_colour_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rhc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rhc_pkg::rsp_type rsp_payload
);
   import rhc_pkg::*;

   localparam int unsigned REV_DLY = DIV_STAGES - REV_STAGES;

   logic        en;
   logic        prep_valid;
   prep_type    prep;
   fwd_tag_type sat_tag_in, sat_tag;
   hue_tag_type hue_tag_in, hue_tag;
   logic        sat_valid, hue_valid;
   logic [DIV_QW-1:0] sat_quot, hue_quot;
   logic [DIV_DW-1:0] sat_rem, hue_rem;
   logic [23:0] rev_rgb;
   logic [23:0] rgb_dly_ff [REV_DLY];
   logic [16:0] hue_val;
   rsp_type     rsp_in, rsp_ff;
   logic        rsp_valid_ff;

   // Advance everything unless a finished result is waiting on a stalled receiver.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   rhc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .req       (req_payload),
      .out_valid (prep_valid),
      .prep      (prep)
   );

   assign sat_tag_in = '{action: prep.action, achro: prep.achro, lightness: prep.lightness};
   assign hue_tag_in = '{hue_neg: prep.hue_neg, hue_base: prep.hue_base};

   // Saturation: span * 65536 / den.
   rhc_div #(
      .NW (SAT_NW),
      .DW (DIV_DW),
      .QW (DIV_QW),
      .TW ($bits(fwd_tag_type))
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .num       (prep.sat_num),
      .den       (prep.sat_den),
      .in_tag    (sat_tag_in),
      .out_valid (sat_valid),
      .quot      (sat_quot),
      .rem       (sat_rem),
      .out_tag   (sat_tag)
   );

   // Hue offset inside the sector: 3840 * |diff| / span.
   rhc_div #(
      .NW (HUE_NW),
      .DW (DIV_DW),
      .QW (DIV_QW),
      .TW ($bits(hue_tag_type))
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .num       (prep.hue_num),
      .den       (prep.hue_den),
      .in_tag    (hue_tag_in),
      .out_valid (hue_valid),
      .quot      (hue_quot),
      .rem       (hue_rem),
      .out_tag   (hue_tag)
   );

   rhc_rev u_rev (
      .clock (clock),
      .en    (en),
      .prep  (prep),
      .rgb   (rev_rgb)
   );

   // Delay the reverse result to meet the divider outputs.
   always_ff @(posedge clock) begin
      if (en) begin
         rgb_dly_ff[0] <= rev_rgb;
         for (int i = 1; i < REV_DLY; i++) begin
            rgb_dly_ff[i] <= rgb_dly_ff[i-1];
         end
      end
   end

   // Assemble the result. A negative offset is a ceiling, hence the remainder test.
   always_comb begin
      if (hue_tag.hue_neg) begin
         hue_val = 17'(hue_tag.hue_base) - hue_quot - 17'(hue_rem != '0);
      end else begin
         hue_val = 17'(hue_tag.hue_base) + hue_quot;
      end
      if (hue_val > 17'(HUE_MAX)) hue_val = 17'(HUE_MAX);

      rsp_in = '0;
      if (sat_tag.action == ACT_RGB_TO_HLS) begin
         rsp_in.out_lightness = sat_tag.lightness;
         if (!sat_tag.achro) begin
            rsp_in.out_hue        = hue_val[14:0];
            rsp_in.out_saturation = (sat_quot > 17'(ONE_Q16)) ? 17'(ONE_Q16) : sat_quot;
         end
      end else begin
         rsp_in.out_red   = rgb_dly_ff[REV_DLY-1][23:16];
         rsp_in.out_green = rgb_dly_ff[REV_DLY-1][15:8];
         rsp_in.out_blue  = rgb_dly_ff[REV_DLY-1][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `RHC_ASSERT_HOLDS(a_div_lockstep, sat_valid == hue_valid, "dividers out of step")
   `RHC_ASSERT_IMPL(a_hue_range, rsp_valid_ff, rsp_ff.out_hue <= 15'(HUE_MAX), "hue out of range")
   `RHC_ASSERT_IMPL(a_one_direction, rsp_valid_ff && (rsp_ff.out_red != 8'd0 || rsp_ff.out_green != 8'd0 || rsp_ff.out_blue != 8'd0), rsp_ff.out_hue == 15'd0 && rsp_ff.out_lightness == 17'd0 && rsp_ff.out_saturation == 17'd0, "both directions present")
   `RHC_ASSERT_NEXT(a_stall_holds, rsp_valid_ff && rsp_stall, $stable(prep_valid) && $stable(sat_valid), "pipeline moved under stall")

endmodule

/* tb/rgb_hls_colour_converter_test.sv */
// Self-checking testbench of the RGB/HLS colour converter.
`timescale 1ns / 100ps

module rgb_hls_colour_converter_test;
   import rhc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   req_type pixel_queue[$];
   rsp_type colour_queue[$];
   bit      stimulus_done = 1'b0;
   int      error_count = 0;
   int      idle_cycles = 0;
   int      send_wait = 0;
   int      recv_wait = 0;
   logic    accepted;

   rgb_hls_colour_converter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   // Sample one point of the hue ramp; lo and hi are Q32 levels, angle in 1/64 degree.
   function automatic logic [7:0] ramp_sample(logic [63:0] lo, logic [63:0] hi, int angle);
      logic [63:0] level;
      logic [63:0] chan;
      if (angle > int'(FULL_TURN)) angle -= FULL_TURN;
      else if (angle < 0) angle += FULL_TURN;
      if (angle < int'(SIXTH_TURN))
         level = lo * SIXTH_TURN + (hi - lo) * 64'(angle);
      else if (angle < 3 * int'(SIXTH_TURN))
         level = hi * SIXTH_TURN;
      else if (angle < 4 * int'(SIXTH_TURN))
         level = lo * SIXTH_TURN + (hi - lo) * 64'(4 * int'(SIXTH_TURN) - angle);
      else
         level = lo * SIXTH_TURN;
      chan = (level * 255) / (64'(SIXTH_TURN) << 32);
      return (chan > 255) ? 8'd255 : chan[7:0];
   endfunction

   // Compute the converted colour for one request.
   function automatic rsp_type convert_colour(req_type px);
      rsp_type     res;
      logic [31:0] r, g, b, mx, mn, span, total, den, hv;
      logic [63:0] num, lv, sv, hi, lo, grey;
      res = '0;
      if (px.action == ACT_RGB_TO_HLS) begin
         r = px.red; g = px.green; b = px.blue;
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         total = mx + mn;
         num = (64'(total) * ONE_Q16) / 510;
         res.out_lightness = (num > ONE_Q16) ? 17'(ONE_Q16) : num[16:0];
         if (mx != mn) begin
            span = mx - mn;
            den = (total < 255) ? total : 510 - total;
            num = (64'(span) * ONE_Q16) / den;
            res.out_saturation = (num > ONE_Q16) ? 17'(ONE_Q16) : num[16:0];
            if (r == mx) begin
               if (g >= b) num = 64'(SIXTH_TURN) * (g - b);
               else num = 64'(FULL_TURN) * span - 64'(SIXTH_TURN) * (b - g);
            end else if (g == mx) begin
               num = 2 * 64'(SIXTH_TURN) * span + 64'(SIXTH_TURN) * b - 64'(SIXTH_TURN) * r;
            end else begin
               num = 4 * 64'(SIXTH_TURN) * span + 64'(SIXTH_TURN) * r - 64'(SIXTH_TURN) * g;
            end
            hv = 32'(num / span);
            res.out_hue = (hv > HUE_MAX) ? 15'(HUE_MAX) : hv[14:0];
         end
      end else begin
         hv = px.hue;
         lv = (px.lightness > ONE_Q16) ? 64'(ONE_Q16) : 64'(px.lightness);
         sv = (px.saturation > ONE_Q16) ? 64'(ONE_Q16) : 64'(px.saturation);
         if (hv >= FULL_TURN) hv -= FULL_TURN;
         if (sv == 0) begin
            grey = (lv * 255) >> 16;
            if (grey > 255) grey = 255;
            res.out_red = grey[7:0]; res.out_green = grey[7:0]; res.out_blue = grey[7:0];
         end else begin
            if (lv <= HALF_Q16) hi = lv * (ONE_Q16 + sv);
            else hi = (lv + sv) * ONE_Q16 - lv * sv;
            lo = 2 * lv * ONE_Q16 - hi;
            res.out_red   = ramp_sample(lo, hi, int'(hv) + int'(THIRD_TURN));
            res.out_green = ramp_sample(lo, hi, int'(hv));
            res.out_blue  = ramp_sample(lo, hi, int'(hv) - int'(THIRD_TURN));
         end
      end
      return res;
   endfunction

   function automatic req_type rgb_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type px;
      px = '0;
      px.action = ACT_RGB_TO_HLS;
      px.red = r; px.green = g; px.blue = b;
      return px;
   endfunction

   function automatic req_type hls_pixel(logic [14:0] h, logic [16:0] l, logic [16:0] s);
      req_type px;
      px = '0;
      px.action = ACT_HLS_TO_RGB;
      px.hue = h; px.lightness = l; px.saturation = s;
      return px;
   endfunction

   // Pick a Q1.16 value biased toward the ends and beyond 1.0.
   function automatic logic [16:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 17'd0;
         1: return 17'(ONE_Q16);
         2: return 17'(HALF_Q16);
         3: return 17'($urandom_range(ONE_Q16 + 1, 131071));
         default: return 17'($urandom_range(0, ONE_Q16));
      endcase
   endfunction

   initial begin
      req_type px;
      // Directed: extremes, achromatic pixels, hue ties, wrap and clamps.
      pixel_queue.push_back(rgb_pixel(8'd0, 8'd0, 8'd0));
      pixel_queue.push_back(rgb_pixel(8'd255, 8'd255, 8'd255));
      pixel_queue.push_back(rgb_pixel(8'd128, 8'd128, 8'd128));
      pixel_queue.push_back(rgb_pixel(8'd255, 8'd0, 8'd0));
      pixel_queue.push_back(rgb_pixel(8'd0, 8'd255, 8'd0));
      pixel_queue.push_back(rgb_pixel(8'd0, 8'd0, 8'd255));
      pixel_queue.push_back(rgb_pixel(8'd255, 8'd0, 8'd1));
      pixel_queue.push_back(rgb_pixel(8'd255, 8'd255, 8'd0));
      pixel_queue.push_back(rgb_pixel(8'd0, 8'd255, 8'd255));
      pixel_queue.push_back(rgb_pixel(8'd255, 8'd0, 8'd255));
      pixel_queue.push_back(rgb_pixel(8'd1, 8'd0, 8'd0));
      pixel_queue.push_back(rgb_pixel(8'd255, 8'd254, 8'd254));
      pixel_queue.push_back(hls_pixel(15'd0, 17'd0, 17'd0));
      pixel_queue.push_back(hls_pixel(15'd0, 17'(ONE_Q16), 17'd0));
      pixel_queue.push_back(hls_pixel(15'd0, 17'd131071, 17'd131071));
      pixel_queue.push_back(hls_pixel(15'd0, 17'(HALF_Q16), 17'(ONE_Q16)));
      pixel_queue.push_back(hls_pixel(15'(SIXTH_TURN), 17'(HALF_Q16), 17'(ONE_Q16)));
      pixel_queue.push_back(hls_pixel(15'(HUE_MAX), 17'(HALF_Q16), 17'(ONE_Q16)));
      pixel_queue.push_back(hls_pixel(15'(FULL_TURN), 17'(HALF_Q16), 17'(ONE_Q16)));
      pixel_queue.push_back(hls_pixel(15'h7FFF, 17'd40000, 17'd30000));
      pixel_queue.push_back(hls_pixel(15'(THIRD_TURN), 17'(HALF_Q16 + 1), 17'd1));
      pixel_queue.push_back(hls_pixel(15'(THIRD_TURN * 2), 17'd20000, 17'd65535));
      // Random part; the unused direction's fields carry noise too.
      repeat (800) begin
         px = req_type'({$urandom, $urandom, $urandom});
         case ($urandom_range(0, 5))
            0: px.hue = 15'($urandom_range(0, 32767));
            1: px.hue = 15'($urandom_range(0, HUE_MAX));
            2: px.hue = 15'(SIXTH_TURN * $urandom_range(0, 6));
            default: px.hue = 15'($urandom_range(0, FULL_TURN));
         endcase
         if (px.action == ACT_HLS_TO_RGB) begin
            px.lightness = pick_level();
            px.saturation = pick_level();
         end else if ($urandom_range(0, 3) == 0) begin
            px.green = px.red;
            if ($urandom_range(0, 1) == 0) px.blue = px.red;
         end
         pixel_queue.push_back(px);
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Driver: hold the payload until the transfer, then wait a random gap.
   always @(posedge clock) begin
      accepted <= !reset && req_valid && !req_stall;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (accepted || !req_valid) begin
            if (send_wait > 0) begin
               req_valid <= 1'b0;
               send_wait <= send_wait - 1;
            end else if (pixel_queue.size() > 0) begin
               req_payload <= pixel_queue[0];
               colour_queue.push_back(convert_colour(pixel_queue[0]));
               void'(pixel_queue.pop_front());
               req_valid <= 1'b1;
               send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            end else begin
               req_valid <= 1'b0;
               stimulus_done <= 1'b1;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (colour_queue.size() == 0) begin
            $error("result with no expectation waiting");
            error_count++;
         end else begin
            exp_rsp = colour_queue.pop_front();
            if (rsp_payload.out_red !== exp_rsp.out_red) begin
               $error("out_red exp %0d got %0d", exp_rsp.out_red, rsp_payload.out_red);
               error_count++;
            end
            if (rsp_payload.out_green !== exp_rsp.out_green) begin
               $error("out_green exp %0d got %0d", exp_rsp.out_green, rsp_payload.out_green);
               error_count++;
            end
            if (rsp_payload.out_blue !== exp_rsp.out_blue) begin
               $error("out_blue exp %0d got %0d", exp_rsp.out_blue, rsp_payload.out_blue);
               error_count++;
            end
            if (rsp_payload.out_hue !== exp_rsp.out_hue) begin
               $error("out_hue exp %0d got %0d", exp_rsp.out_hue, rsp_payload.out_hue);
               error_count++;
            end
            if (rsp_payload.out_lightness !== exp_rsp.out_lightness) begin
               $error("out_lightness exp %0d got %0d", exp_rsp.out_lightness,
                      rsp_payload.out_lightness);
               error_count++;
            end
            if (rsp_payload.out_saturation !== exp_rsp.out_saturation) begin
               $error("out_saturation exp %0d got %0d", exp_rsp.out_saturation,
                      rsp_payload.out_saturation);
               error_count++;
            end
         end
      end
   end

   // Receiver back-pressure: stall for a random count after each transfer.
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid)
               recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (!reset);
      fork
         wait (stimulus_done && colour_queue.size() == 0);
         wait (idle_cycles >= WATCHDOG_LIMIT);
      join_any
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL rgb_hls_colour_converter");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (error_count == 0) begin
            $display("PASS rgb_hls_colour_converter");
         end else begin
            $display("FAIL rgb_hls_colour_converter");
         end
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_prep.sv
sv/rhc_div.sv
sv/rhc_rev.sv
sv/rgb_hls_colour_converter.sv
tb/rgb_hls_colour_converter_test.sv
